@@ rtl/civil_date_day_converter_macros.svh @@
// Assertion macros for the civil date / day number converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CIVIL_DATE_DAY_CONVERTER_MACROS_SVH
`define CIVIL_DATE_DAY_CONVERTER_MACROS_SVH

// Same-cycle implication, off during reset.
`define CCD_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("civil date converter check failed");

// Delayed implication, off during reset.
`define CCD_ASSERT_DELAY(label, pre, dly, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##(dly) (post)) \
        else $error("civil date converter latency check failed");

`endif

@@ rtl/ccd_pkg.sv @@
// Shared constants, result types and month table for the date converter.
// No dependencies.
`timescale 1ns / 1ps

package ccd_pkg;

    localparam int KEY_W = 27;
    localparam int DAY_W = 23;

    // Core pipeline depth of both conversion paths, plus one output stage.
    localparam int CORE_STAGES = 11;
    localparam int LATENCY     = CORE_STAGES + 1;
    // Delay stages that bring the key-to-day path to the core depth.
    localparam int DAYS_PAD    = 3;

    localparam logic signed [DAY_W-1:0] MIN_DAY = -23'sd719162;
    localparam logic signed [DAY_W-1:0] MAX_DAY = 23'sd2932896;
    localparam logic [DAY_W-1:0]        EPOCH_SHIFT = 23'd719468;
    localparam logic [21:0]             ERA_DAYS = 22'd146097;

    // Reciprocals: q = (x * M) >> K, exact over the operand range used.
    localparam logic [27:0] RECIP_10000 = 28'd219902326;  // K = 41
    localparam logic [14:0] RECIP_100A  = 15'd20972;      // K = 21
    localparam logic [14:0] RECIP_400   = 15'd20972;      // K = 23
    localparam logic [9:0]  RECIP_100B  = 10'd656;        // K = 16
    localparam logic [22:0] RECIP_ERA   = 23'd7525902;    // K = 40
    localparam logic [18:0] RECIP_1460  = 19'd367720;     // K = 29
    localparam logic [18:0] RECIP_36524 = 19'd470373;     // K = 34
    localparam logic [18:0] RECIP_365   = 19'd367720;     // K = 27
    localparam logic [11:0] RECIP_153   = 12'd3427;       // K = 19

    typedef struct packed {
        logic                    valid;
        logic signed [DAY_W-1:0] day;
    } ccd_day_res_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } ccd_key_res_t;

    // Days from March 1 to the first of month index mp (0 = March).
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/ccd_to_days.sv @@
// Date key to day number path: 8 arithmetic stages plus delay to core depth.
// Depends on ccd_pkg.
`timescale 1ns / 1ps

module ccd_to_days (
    input  logic                       clk,
    input  logic [ccd_pkg::KEY_W-1:0]  date_key,
    output ccd_pkg::ccd_day_res_t      res
);

    // stage 1: year
    logic [54:0] y_prod;
    logic [26:0] s1_key_reg;
    logic [13:0] s1_y_reg;

    // stage 2: month*100 + day remainder
    logic [26:0] ymul;
    logic [26:0] rem_full;
    logic [13:0] s2_y_reg;
    logic [13:0] s2_rem_reg;

    // stage 3: month
    logic [28:0] m_prod;
    logic [13:0] s3_y_reg;
    logic [13:0] s3_rem_reg;
    logic [6:0]  s3_m_reg;

    // stage 4: day, range check, March-based year and month
    logic [6:0]  day_next;
    logic        valid_next;
    logic [13:0] ay_next;
    logic [6:0]  mp_full;
    logic [13:0] s4_ay_reg;
    logic [3:0]  s4_mp_reg;
    logic [4:0]  s4_d_reg;
    logic        s4_valid_reg;

    // stage 5: era, day of year
    logic [28:0] era_prod;
    logic [8:0]  doy_next;
    logic [13:0] s5_ay_reg;
    logic [4:0]  s5_era_reg;
    logic [8:0]  s5_doy_reg;
    logic        s5_valid_reg;

    // stage 6: year of era
    logic [13:0] era400;
    logic [8:0]  s6_yoe_reg;
    logic [4:0]  s6_era_reg;
    logic [8:0]  s6_doy_reg;
    logic        s6_valid_reg;

    // stage 7: partial day-of-era terms
    logic [17:0] t1_next;
    logic [18:0] q100_prod;
    logic [21:0] eraday_next;
    logic [17:0] s7_t1_reg;
    logic [2:0]  s7_q100_reg;
    logic [21:0] s7_eraday_reg;
    logic [8:0]  s7_doy_reg;
    logic        s7_valid_reg;

    // stage 8: final sum
    logic [22:0] sum_next;
    ccd_pkg::ccd_day_res_t s8_res_reg;

    ccd_pkg::ccd_day_res_t pad_reg [ccd_pkg::DAYS_PAD];

    always_comb
    begin
        y_prod = 55'(date_key) * 55'(ccd_pkg::RECIP_10000);

        ymul     = 27'(s1_y_reg) * 27'd10000;
        rem_full = s1_key_reg - ymul;

        m_prod = 29'(s2_rem_reg) * 29'(ccd_pkg::RECIP_100A);

        day_next   = s3_rem_reg[6:0] - 7'(s3_m_reg * 7'd100);
        valid_next = (s3_y_reg >= 14'd1) && (s3_y_reg <= 14'd9999) &&
                     (s3_m_reg >= 7'd1) && (s3_m_reg <= 7'd12) &&
                     (day_next >= 7'd1) && (day_next <= 7'd31);
        ay_next    = s3_y_reg - ((s3_m_reg <= 7'd2) ? 14'd1 : 14'd0);
        mp_full    = (s3_m_reg > 7'd2) ? s3_m_reg - 7'd3 : s3_m_reg + 7'd9;

        era_prod = 29'(s4_ay_reg) * 29'(ccd_pkg::RECIP_400);
        doy_next = ccd_pkg::cum_days(s4_mp_reg) + 9'(s4_d_reg) - 9'd1;

        era400 = 14'(s5_era_reg) * 14'd400;

        t1_next     = 18'(s6_yoe_reg) * 18'd365 + 18'(s6_yoe_reg[8:2]);
        q100_prod   = 19'(s6_yoe_reg) * 19'(ccd_pkg::RECIP_100B);
        eraday_next = 22'(s6_era_reg) * ccd_pkg::ERA_DAYS;

        // modulo 2^23 arithmetic gives the two's complement day directly
        sum_next = 23'(s7_eraday_reg) + 23'(s7_t1_reg) + 23'(s7_doy_reg)
                   - 23'(s7_q100_reg) - ccd_pkg::EPOCH_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        s1_key_reg <= date_key;
        s1_y_reg   <= y_prod[54:41];

        s2_y_reg   <= s1_y_reg;
        s2_rem_reg <= rem_full[13:0];

        s3_y_reg   <= s2_y_reg;
        s3_rem_reg <= s2_rem_reg;
        s3_m_reg   <= m_prod[27:21];

        s4_ay_reg    <= ay_next;
        s4_mp_reg    <= mp_full[3:0];
        s4_d_reg     <= day_next[4:0];
        s4_valid_reg <= valid_next;

        s5_ay_reg    <= s4_ay_reg;
        s5_era_reg   <= era_prod[27:23];
        s5_doy_reg   <= doy_next;
        s5_valid_reg <= s4_valid_reg;

        s6_yoe_reg   <= 9'(s5_ay_reg - era400);
        s6_era_reg   <= s5_era_reg;
        s6_doy_reg   <= s5_doy_reg;
        s6_valid_reg <= s5_valid_reg;

        s7_t1_reg     <= t1_next;
        s7_q100_reg   <= q100_prod[18:16];
        s7_eraday_reg <= eraday_next;
        s7_doy_reg    <= s6_doy_reg;
        s7_valid_reg  <= s6_valid_reg;

        s8_res_reg.valid <= s7_valid_reg;
        s8_res_reg.day   <= s7_valid_reg ? signed'(sum_next) : '0;

        pad_reg[0] <= s8_res_reg;
        for (int i = 1; i < ccd_pkg::DAYS_PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    assign res = pad_reg[ccd_pkg::DAYS_PAD-1];

endmodule

@@ rtl/ccd_to_key.sv @@
// Day number to date key path: 11 register stages of reciprocal arithmetic.
// Depends on ccd_pkg.
`timescale 1ns / 1ps

module ccd_to_key (
    input  logic                              clk,
    input  logic signed [ccd_pkg::DAY_W-1:0]  day_number,
    output ccd_pkg::ccd_key_res_t             res
);

    // stage 1: span check, shift to era origin
    logic [22:0] s_next;
    logic [21:0] s1_s_reg;
    logic        s1_valid_reg;

    // stage 2: era
    logic [44:0] era_prod;
    logic [21:0] s2_s_reg;
    logic [4:0]  s2_era_reg;
    logic        s2_valid_reg;

    // stage 3: day of era
    logic [21:0] era_days;
    logic [21:0] doe_full;
    logic [17:0] s3_doe_reg;
    logic [4:0]  s3_era_reg;
    logic        s3_valid_reg;

    // stage 4: four-year cycle correction
    logic [36:0] q1460_prod;
    logic [17:0] s4_doe_reg;
    logic [4:0]  s4_era_reg;
    logic [6:0]  s4_q1460_reg;
    logic        s4_valid_reg;

    // stage 5: century correction
    logic [36:0] q36524_prod;
    logic [17:0] n0_next;
    logic [17:0] s5_doe_reg;
    logic [4:0]  s5_era_reg;
    logic [17:0] s5_n0_reg;
    logic [2:0]  s5_q36524_reg;
    logic        s5_valid_reg;

    // stage 6: year of era
    logic [17:0] n_next;
    logic [36:0] yoe_prod;
    logic [17:0] s6_doe_reg;
    logic [4:0]  s6_era_reg;
    logic [8:0]  s6_yoe_reg;
    logic        s6_valid_reg;

    // stage 7: year start terms
    logic [17:0] t_next;
    logic [18:0] q100_prod;
    logic [13:0] y_next;
    logic [17:0] s7_doe_reg;
    logic [17:0] s7_t_reg;
    logic [2:0]  s7_q100_reg;
    logic [13:0] s7_y_reg;
    logic        s7_valid_reg;

    // stage 8: day of year
    logic [17:0] doy_full;
    logic [8:0]  s8_doy_reg;
    logic [13:0] s8_y_reg;
    logic        s8_valid_reg;

    // stage 9: March-based month
    logic [10:0] x_next;
    logic [22:0] mp_prod;
    logic [8:0]  s9_doy_reg;
    logic [13:0] s9_y_reg;
    logic [3:0]  s9_mp_reg;
    logic        s9_valid_reg;

    // stage 10: civil day, month, year
    logic [8:0]  d_full;
    logic [3:0]  m_next;
    logic [13:0] yy_next;
    logic [4:0]  s10_d_reg;
    logic [3:0]  s10_m_reg;
    logic [13:0] s10_y_reg;
    logic        s10_valid_reg;

    // stage 11: decimal key
    logic [26:0] key_next;
    ccd_pkg::ccd_key_res_t s11_res_reg;

    always_comb
    begin
        s_next = unsigned'(day_number) + ccd_pkg::EPOCH_SHIFT;

        era_prod = 45'(s1_s_reg) * 45'(ccd_pkg::RECIP_ERA);

        era_days = 22'(s2_era_reg) * ccd_pkg::ERA_DAYS;
        doe_full = s2_s_reg - era_days;

        q1460_prod = 37'(s3_doe_reg) * 37'(ccd_pkg::RECIP_1460);

        q36524_prod = 37'(s4_doe_reg) * 37'(ccd_pkg::RECIP_36524);
        // last day of a 400-year era
        n0_next = s4_doe_reg - 18'(s4_q1460_reg)
                  - ((s4_doe_reg == 18'd146096) ? 18'd1 : 18'd0);

        n_next   = s5_n0_reg + 18'(s5_q36524_reg);
        yoe_prod = 37'(n_next) * 37'(ccd_pkg::RECIP_365);

        t_next    = 18'(s6_yoe_reg) * 18'd365 + 18'(s6_yoe_reg[8:2]);
        q100_prod = 19'(s6_yoe_reg) * 19'(ccd_pkg::RECIP_100B);
        y_next    = 14'(s6_era_reg) * 14'd400 + 14'(s6_yoe_reg);

        doy_full = s7_doe_reg - s7_t_reg + 18'(s7_q100_reg);

        x_next  = 11'(s8_doy_reg) * 11'd5 + 11'd2;
        mp_prod = 23'(x_next) * 23'(ccd_pkg::RECIP_153);

        d_full  = s9_doy_reg - ccd_pkg::cum_days(s9_mp_reg) + 9'd1;
        m_next  = (s9_mp_reg < 4'd10) ? s9_mp_reg + 4'd3 : s9_mp_reg - 4'd9;
        // January and February belong to the next civil year
        yy_next = s9_y_reg + ((s9_mp_reg >= 4'd10) ? 14'd1 : 14'd0);

        key_next = 27'(s10_y_reg) * 27'd10000 + 27'(s10_m_reg) * 27'd100
                   + 27'(s10_d_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_s_reg     <= s_next[21:0];
        s1_valid_reg <= (day_number >= ccd_pkg::MIN_DAY) &&
                        (day_number <= ccd_pkg::MAX_DAY);

        s2_s_reg     <= s1_s_reg;
        s2_era_reg   <= era_prod[44:40];
        s2_valid_reg <= s1_valid_reg;

        s3_doe_reg   <= doe_full[17:0];
        s3_era_reg   <= s2_era_reg;
        s3_valid_reg <= s2_valid_reg;

        s4_doe_reg   <= s3_doe_reg;
        s4_era_reg   <= s3_era_reg;
        s4_q1460_reg <= q1460_prod[35:29];
        s4_valid_reg <= s3_valid_reg;

        s5_doe_reg    <= s4_doe_reg;
        s5_era_reg    <= s4_era_reg;
        s5_n0_reg     <= n0_next;
        s5_q36524_reg <= q36524_prod[36:34];
        s5_valid_reg  <= s4_valid_reg;

        s6_doe_reg   <= s5_doe_reg;
        s6_era_reg   <= s5_era_reg;
        s6_yoe_reg   <= yoe_prod[35:27];
        s6_valid_reg <= s5_valid_reg;

        s7_doe_reg   <= s6_doe_reg;
        s7_t_reg     <= t_next;
        s7_q100_reg  <= q100_prod[18:16];
        s7_y_reg     <= y_next;
        s7_valid_reg <= s6_valid_reg;

        s8_doy_reg   <= doy_full[8:0];
        s8_y_reg     <= s7_y_reg;
        s8_valid_reg <= s7_valid_reg;

        s9_doy_reg   <= s8_doy_reg;
        s9_y_reg     <= s8_y_reg;
        s9_mp_reg    <= mp_prod[22:19];
        s9_valid_reg <= s8_valid_reg;

        s10_d_reg     <= d_full[4:0];
        s10_m_reg     <= m_next;
        s10_y_reg     <= yy_next;
        s10_valid_reg <= s9_valid_reg;

        s11_res_reg.valid <= s10_valid_reg;
        s11_res_reg.key   <= s10_valid_reg ? key_next : '0;
    end

    assign res = s11_res_reg;

endmodule

@@ rtl/civil_date_day_converter.sv @@
// Civil date / day number converter. Each accepted start yields one done pulse.
// Throughput: one item per clock; busy stays low, so start may be high every cycle.
// The depth is set by the day-to-key chain of reciprocal multiplies (11 stages + output).
// Reset (rst_n, async low) clears only the valid pipeline and done; no result is lost
// or stalled, since the receiver takes each done pulse as it comes.
// Depends on ccd_pkg, ccd_to_days, ccd_to_key and the assertion macro header.
`timescale 1ns / 1ps

`include "civil_date_day_converter_macros.svh"

module civil_date_day_converter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              mode,
    input  logic [ccd_pkg::KEY_W-1:0]         date_key,
    input  logic signed [ccd_pkg::DAY_W-1:0]  day_number,
    output logic                              done,
    output logic signed [ccd_pkg::DAY_W-1:0]  day_result,
    output logic [ccd_pkg::KEY_W-1:0]         key_result,
    output logic                              valid_res
);

    localparam int STAGES = ccd_pkg::CORE_STAGES;

    // Both paths run on every item; the mode bit travels alongside and picks
    // the result at the output register.
    ccd_pkg::ccd_day_res_t days_res;
    ccd_pkg::ccd_key_res_t key_res;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              mode_reg [STAGES];

    logic                             done_reg;
    logic signed [ccd_pkg::DAY_W-1:0] day_result_reg;
    logic [ccd_pkg::KEY_W-1:0]        key_result_reg;
    logic                             valid_res_reg;

    // day result lies within 0001-01-01 .. 9999-12-31
    logic                             day_in_span;

    ccd_to_days u_to_days (
        .clk      (clk),
        .date_key (date_key),
        .res      (days_res)
    );

    ccd_to_key u_to_key (
        .clk        (clk),
        .day_number (day_number),
        .res        (key_res)
    );

    // Pipeline never stalls.
    assign busy = 1'b0;

    assign vld_next = {vld_reg[STAGES-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[STAGES-1];
        end
    end

    // mode line and result payload carry no reset
    always_ff @(posedge clk)
    begin
        mode_reg[0] <= mode;
        for (int i = 1; i < STAGES; i++)
        begin
            mode_reg[i] <= mode_reg[i-1];
        end

        if (mode_reg[STAGES-1])
        begin
            day_result_reg <= '0;
            key_result_reg <= key_res.key;
            valid_res_reg  <= key_res.valid;
        end
        else
        begin
            day_result_reg <= days_res.day;
            key_result_reg <= '0;
            valid_res_reg  <= days_res.valid;
        end
    end

    assign done       = done_reg;
    assign day_result = day_result_reg;
    assign key_result = key_result_reg;
    assign valid_res  = valid_res_reg;

    assign day_in_span = (day_result >= ccd_pkg::MIN_DAY) && (day_result <= ccd_pkg::MAX_DAY);

    // every accepted item comes out with a done pulse
    `CCD_ASSERT_DELAY(a_start_to_done, start, ccd_pkg::LATENCY, done)
    // no result without an earlier accepted item
    `CCD_ASSERT_IMPL(a_done_has_item, done, $past(start, ccd_pkg::LATENCY))
    // rejected inputs give all-zero results
    `CCD_ASSERT_IMPL(a_invalid_zero, done && !valid_res, day_result == '0 && key_result == '0)
    // only the field of the selected mode can be nonzero
    `CCD_ASSERT_IMPL(a_one_field, done, day_result == '0 || key_result == '0)
    // a valid key-to-day result lies in the supported span
    `CCD_ASSERT_IMPL(a_day_span, done && valid_res && key_result == '0, day_in_span)

endmodule

@@ tb/civil_date_day_converter_test.sv @@
// Self-checking testbench for civil_date_day_converter: date key <-> day number conversion.
// Depends on ccd_pkg (widths, latency) and the RTL top; predicts each result in-line.
`timescale 1ns / 1ps

module civil_date_day_converter_test;

    localparam int KEY_W = ccd_pkg::KEY_W;
    localparam int DAY_W = ccd_pkg::DAY_W;

    // Supported span of day numbers: 0001-01-01 .. 9999-12-31
    localparam longint FIRST_DAY = -719162;
    localparam longint LAST_DAY  = 2932896;

    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_AT     = 300;   // sender waits for an empty pipe here
    localparam int CALM_FROM    = 500;   // no sender idling in [CALM_FROM, CALM_TO)
    localparam int CALM_TO      = 800;
    localparam int STALL_LIMIT  = 4000;  // cycles with no accept and no result

    typedef enum logic { MODE_KEY_TO_DAYS = 1'b0, MODE_DAYS_TO_KEY = 1'b1 } conv_mode_t;

    typedef struct {
        conv_mode_t              mode;
        logic [KEY_W-1:0]        key;
        logic signed [DAY_W-1:0] day;
    } date_item_t;

    typedef struct {
        logic signed [DAY_W-1:0] day;
        logic [KEY_W-1:0]        key;
        logic                    valid;
    } conversion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    start = 1'b0;
    logic                    mode = 1'b0;
    logic [KEY_W-1:0]        date_key = '0;
    logic signed [DAY_W-1:0] day_number = '0;

    logic                    busy;
    logic                    done;
    logic signed [DAY_W-1:0] day_result;
    logic [KEY_W-1:0]        key_result;
    logic                    valid_res;

    date_item_t  date_items[$];        // items still to be sent, front is on the ports
    conversion_t expected_results[$];  // one per accepted item, oldest first

    int items_sent = 0;
    int error_count = 0;
    int quiet_cycles = 0;
    bit sender_idle;
    bit drain_wait;

    civil_date_day_converter u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .date_key   (date_key),
        .day_number (day_number),
        .done       (done),
        .day_result (day_result),
        .key_result (key_result),
        .valid_res  (valid_res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. Era arithmetic: 400-year eras of 146097 days, years
    // starting on March 1, shifted so that 1970-01-01 is day 0.
    // ------------------------------------------------------------------
    function automatic conversion_t convert_item(date_item_t it);
        conversion_t res;
        longint k, y, m, d, ay, era, yoe, mp, doy, doe, dv, s, kv;
        res.day   = '0;
        res.key   = '0;
        res.valid = 1'b0;
        if (it.mode == MODE_KEY_TO_DAYS)
        begin
            k = longint'(it.key);
            y = k / 10000;
            m = (k / 100) % 100;
            d = k % 100;
            // Only the field ranges are checked; a day past the month end
            // simply rolls into the next month through the arithmetic.
            if (y >= 1 && y <= 9999 && m >= 1 && m <= 12 && d >= 1 && d <= 31)
            begin
                ay  = y - ((m <= 2) ? 1 : 0);
                era = ay / 400;
                yoe = ay - era * 400;
                mp  = (m > 2) ? m - 3 : m + 9;
                doy = (153 * mp + 2) / 5 + d - 1;
                doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
                dv  = era * 146097 + doe - 719468;
                res.day   = dv[DAY_W-1:0];
                res.valid = 1'b1;
            end
        end
        else
        begin
            dv = longint'(it.day);   // sign-extended
            if (dv >= FIRST_DAY && dv <= LAST_DAY)
            begin
                s   = dv + 719468;
                era = s / 146097;
                doe = s - era * 146097;
                yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
                y   = era * 400 + yoe;
                doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
                mp  = (5 * doy + 2) / 153;
                d   = doy - (153 * mp + 2) / 5 + 1;
                m   = (mp < 10) ? mp + 3 : mp - 9;
                if (mp >= 10)
                    y = y + 1;
                kv = y * 10000 + m * 100 + d;
                res.key   = kv[KEY_W-1:0];
                res.valid = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic add_item(input conv_mode_t m, input longint key_val, input longint day_val);
        date_item_t it;
        it.mode = m;
        it.key  = key_val[KEY_W-1:0];
        it.day  = day_val[DAY_W-1:0];
        date_items.insert(date_items.size(), it);
    endtask

    // Random item, mostly well-formed; the unused field always carries noise.
    task automatic add_random_item();
        int unsigned pick;
        longint yr, mo, dy;
        pick = $urandom_range(99, 0);
        if (pick < 45)
        begin
            yr = longint'($urandom_range(9999, 1));
            mo = longint'($urandom_range(12, 1));
            dy = longint'($urandom_range(31, 1));
            add_item(MODE_KEY_TO_DAYS, yr * 10000 + mo * 100 + dy, longint'($urandom()));
        end
        else if (pick < 85)
        begin
            dy = longint'($urandom_range(32'(LAST_DAY - FIRST_DAY), 0));
            add_item(MODE_DAYS_TO_KEY, longint'($urandom()), dy + FIRST_DAY);
        end
        else if (pick < 92)
        begin
            add_item(MODE_KEY_TO_DAYS, longint'($urandom()), longint'($urandom()));
        end
        else
        begin
            add_item(MODE_DAYS_TO_KEY, longint'($urandom()), longint'($urandom()));
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: the front of date_items sits on the ports while start is
    // high; it is popped at the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), convert_item(date_items[0]));
                date_items.pop_front();
                items_sent++;
            end
            sender_idle = (items_sent < CALM_FROM || items_sent >= CALM_TO)
                          && ($urandom_range(99, 0) < 23);
            // One pause that lets the pipeline run completely dry.
            drain_wait = (items_sent == DRAIN_AT) && (expected_results.size() != 0);
            if (start && busy)
            begin
                // item not taken yet: keep it on the ports
            end
            else if (date_items.size() == 0 || sender_idle || drain_wait)
            begin
                start <= 1'b0;
            end
            else
            begin
                start      <= 1'b1;
                mode       <= date_items[0].mode;
                date_key   <= date_items[0].key;
                day_number <= date_items[0].day;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done pulse is one result item, checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        conversion_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got day %0d key %0d valid %0b",
                         $time, day_result, key_result, valid_res);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (day_result !== exp_res.day)
                begin
                    $display("%0t: day_result expected %0d got %0d",
                             $time, exp_res.day, day_result);
                    error_count++;
                end
                if (key_result !== exp_res.key)
                begin
                    $display("%0t: key_result expected %0d got %0d",
                             $time, exp_res.key, key_result);
                    error_count++;
                end
                if (valid_res !== exp_res.valid)
                begin
                    $display("%0t: valid_res expected %0b got %0b",
                             $time, exp_res.valid, valid_res);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without an accepted item or a result ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        // Directed: field extremes and every special case.
        add_item(MODE_KEY_TO_DAYS, 0, 0);               // all-zero key
        add_item(MODE_KEY_TO_DAYS, 10101, -1);          // 0001-01-01, first day
        add_item(MODE_KEY_TO_DAYS, 10131, 0);           // January, day 31
        add_item(MODE_KEY_TO_DAYS, 99991231, 0);        // last supported day
        add_item(MODE_KEY_TO_DAYS, 19700101, 4194303);  // epoch
        add_item(MODE_KEY_TO_DAYS, 20000229, 0);        // leap day, 400-year rule
        add_item(MODE_KEY_TO_DAYS, 19000229, 0);        // no leap in 1900: rolls to March 1
        add_item(MODE_KEY_TO_DAYS, 20230231, 0);        // rolls into March
        add_item(MODE_KEY_TO_DAYS, 1231, 0);            // year 0
        add_item(MODE_KEY_TO_DAYS, 100000101, 0);       // year 10000
        add_item(MODE_KEY_TO_DAYS, 20230001, 0);        // month 0
        add_item(MODE_KEY_TO_DAYS, 20231301, 0);        // month 13
        add_item(MODE_KEY_TO_DAYS, 20230100, 0);        // day 0
        add_item(MODE_KEY_TO_DAYS, 20230132, 0);        // day 32
        add_item(MODE_KEY_TO_DAYS, 99999999, 0);
        add_item(MODE_KEY_TO_DAYS, 134217727, -4194304); // every key bit set
        add_item(MODE_DAYS_TO_KEY, 0, FIRST_DAY);
        add_item(MODE_DAYS_TO_KEY, 134217727, LAST_DAY);
        add_item(MODE_DAYS_TO_KEY, 0, FIRST_DAY - 1);   // just below the span
        add_item(MODE_DAYS_TO_KEY, 0, LAST_DAY + 1);    // just above the span
        add_item(MODE_DAYS_TO_KEY, 0, 0);
        add_item(MODE_DAYS_TO_KEY, 0, -1);
        add_item(MODE_DAYS_TO_KEY, 0, 11016);           // 2000-02-29
        add_item(MODE_DAYS_TO_KEY, 0, -4194304);        // most negative field value
        add_item(MODE_DAYS_TO_KEY, 0, 4194303);         // most positive field value

        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_item();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (date_items.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // Catch stray results trailing the last expected one.
        repeat (2 * ccd_pkg::LATENCY) @(posedge clk);

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ccd_pkg.sv
rtl/ccd_to_days.sv
rtl/ccd_to_key.sv
rtl/civil_date_day_converter.sv
tb/civil_date_day_converter_test.sv
